// ===== src/bdr_pkg.sv =====
// Shared types, codes and helpers for the block download receiver.
package bdr_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int FRAME_BYTES = 7;
    localparam int ADDR_W      = 8;   // byte address inside one block
    localparam int BLK_W       = 9;   // holds 0..BLOCK_BYTES
    localparam int SIZE_W      = 21;  // image size and byte count, up to 2^20
    localparam int MAP_W       = 37;
    localparam int CFG_IDX_W   = 3;

    localparam logic [10:0] BOOT_FRAME_ID = 11'h100;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

    // frames per block: floor(x / FRAME_BYTES) = (x * RECIP) >> RECIP_SH, x < 512
    localparam int RECIP    = 293;
    localparam int RECIP_SH = 11;

    // opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_JUMP  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_MAP  = 2'd2;
    localparam logic [1:0] KIND_WORD = 2'd3;

    // error codes
    localparam logic [3:0] ERR_LENGTH     = 4'd0;
    localparam logic [3:0] ERR_SEQUENCE   = 4'd1;
    localparam logic [3:0] ERR_SIZE       = 4'd2;
    localparam logic [3:0] ERR_ERASE      = 4'd3;
    localparam logic [3:0] ERR_STATE      = 4'd4;
    localparam logic [3:0] ERR_INCOMPLETE = 4'd5;
    localparam logic [3:0] ERR_WRITE      = 4'd6;
    localparam logic [3:0] ERR_CRC        = 4'd7;
    localparam logic [3:0] ERR_IMAGE      = 4'd8;

    // download phases
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RECV     = 2'd1;
    localparam logic [1:0] PH_VERIFIED = 2'd2;
    localparam logic [1:0] PH_FAILED   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IMAGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE = 3'd3;

    // decode outcome for one frame
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [1:0]  opcode;
        logic [5:0]  seq;
        logic [3:0]  frame_len;
        logic [55:0] payload;
        logic        flash_ok;
    } t_frame;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  err_code;
        logic [36:0] frame_map;
        logic [19:0] write_offset;
        logic [63:0] write_data;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [20:0] max_image_bytes;
        logic [31:0] ram_low;
        logic [31:0] ram_high;
        logic [31:0] image_base;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              wr_en;
        logic [2:0]        wr_idx;
        logic              mark;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       complete;
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int j = 0; j < 8; j++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== src/bdr_ctrl.sv =====
// Sequencer for frame decode, byte writes, block readout and commit.
module bdr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bdr_pkg::t_status i_status,
    output bdr_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WBYTE  = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [bdr_pkg::BLK_W-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                n_cnt      = '0;
                if (i_status.act == bdr_pkg::ACT_WRITE) begin
                    n_state = S_WBYTE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WBYTE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_idx = r_cnt[2:0];
                if (r_cnt == bdr_pkg::BLK_W'(bdr_pkg::FRAME_BYTES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MARK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = i_status.complete ? S_READ : S_IDLE;
            end
            S_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_cnt[bdr_pkg::ADDR_W-1:0];
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == bdr_pkg::BLK_W'(bdr_pkg::BLOCK_BYTES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bdr_datapath.sv =====
// Frame checks, block store, bitmap, CRC and result register.
module bdr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdr_pkg::t_cfg    i_cfg,
    input  bdr_pkg::t_frame  i_frame,
    input  bdr_pkg::t_cmd    i_cmd,
    output bdr_pkg::t_status o_status,
    output logic             o_valid,
    output bdr_pkg::t_result o_result
);

    localparam int AW = bdr_pkg::ADDR_W;
    localparam int BW = bdr_pkg::BLK_W;
    localparam int SW = bdr_pkg::SIZE_W;
    localparam int MW = bdr_pkg::MAP_W;

    // block store: byte memory plus a valid bit per byte (invalid reads 0xFF)
    logic [7:0]                      mem [bdr_pkg::BLOCK_BYTES];
    logic [bdr_pkg::BLOCK_BYTES-1:0] r_vbit;
    logic [7:0]                      r_rd_byte;
    logic                            r_rd_vb;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_addr;

    bdr_pkg::t_frame  r_frm;
    logic [1:0]       r_phase;
    logic [MW-1:0]    r_seen;
    logic [SW-1:0]    r_image_size;
    logic [SW-1:0]    r_bytes_done;
    logic [31:0]      r_crc;
    logic [31:0]      r_crc_tmp;
    logic [63:0]      r_vec;
    logic [63:0]      r_vec_tmp;
    logic [55:0]      r_word;
    logic             r_valid;
    bdr_pkg::t_result r_res;

    // derived block geometry
    logic [SW-1:0]   rem;
    logic [BW-1:0]   blk;
    logic [BW-1:0]   blk_p6;
    logic [2*BW-1:0] fr_prod;
    logic [5:0]      frames;
    logic [BW-1:0]   off;
    logic [BW-1:0]   fr;
    logic [2:0]      plen;
    logic [MW-1:0]   target;
    logic [MW-1:0]   bitmask;
    logic [MW-1:0]   seen_new;
    logic            is_last_frame;
    logic            dup;
    logic [31:0]     word;
    logic            vec_ok;
    logic [32:0]     img_end;
    logic [31:0]     sp;
    logic [31:0]     rv;
    logic [31:0]     ra;

    // decode outcome
    logic [1:0] d_act;
    logic [1:0] d_kind;
    logic [3:0] d_code;
    logic [MW-1:0] d_map;
    logic       d_set_ph;
    logic [1:0] d_ph;
    logic       d_init;

    // write and readout helpers
    logic [BW-1:0] wr_pos;
    logic          wr_ok;
    logic [7:0]    rd_b;
    logic [63:0]   full_word;

    assign word    = r_frm.payload[31:0];
    assign rem     = r_image_size - r_bytes_done;
    assign blk     = (rem > SW'(bdr_pkg::BLOCK_BYTES)) ? BW'(bdr_pkg::BLOCK_BYTES) : rem[BW-1:0];
    assign blk_p6  = blk + BW'(bdr_pkg::FRAME_BYTES - 1);
    assign fr_prod = blk_p6 * BW'(bdr_pkg::RECIP);
    assign frames  = 6'(fr_prod >> bdr_pkg::RECIP_SH);
    assign off     = BW'(r_frm.seq) * BW'(bdr_pkg::FRAME_BYTES);
    assign fr      = blk - off;
    assign plen    = (fr > BW'(bdr_pkg::FRAME_BYTES)) ? 3'(bdr_pkg::FRAME_BYTES) : fr[2:0];
    assign target  = MW'((38'(1) << frames) - 38'(1));
    assign bitmask = MW'(64'(1) << r_frm.seq);
    assign seen_new      = r_seen | bitmask;
    assign is_last_frame = (r_frm.seq == frames - 6'd1);
    assign dup           = |(r_seen & bitmask);

    assign sp      = r_vec[31:0];
    assign rv      = r_vec[63:32];
    assign ra      = {rv[31:1], 1'b0};
    assign img_end = {1'b0, i_cfg.image_base} + 33'(i_cfg.max_image_bytes);
    assign vec_ok  = (sp >= i_cfg.ram_low) && (sp <= i_cfg.ram_high) && (sp[1:0] == 2'b00)
                  && rv[0] && (ra >= i_cfg.image_base) && ({1'b0, ra} < img_end);

    always_comb begin
        d_act    = bdr_pkg::ACT_REPLY;
        d_kind   = bdr_pkg::KIND_ERR;
        d_code   = bdr_pkg::ERR_LENGTH;
        d_map    = '0;
        d_set_ph = 1'b0;
        d_ph     = bdr_pkg::PH_FAILED;
        d_init   = 1'b0;
        if (r_frm.frame_id != bdr_pkg::BOOT_FRAME_ID || r_frm.frame_len == 4'd0) begin
            d_act = bdr_pkg::ACT_NONE;
        end else begin
            case (r_frm.opcode)
                bdr_pkg::OP_START: begin
                    if (r_frm.frame_len != 4'd5) begin
                        d_code = bdr_pkg::ERR_LENGTH;
                    end else if (r_frm.seq != 6'd0) begin
                        d_code = bdr_pkg::ERR_SEQUENCE;
                    end else if (word == 32'd0 || word > 32'(i_cfg.max_image_bytes)) begin
                        d_code = bdr_pkg::ERR_SIZE;
                    end else if (r_frm.flash_ok) begin
                        d_kind   = bdr_pkg::KIND_ACK;
                        d_code   = bdr_pkg::ERR_LENGTH;
                        d_init   = 1'b1;
                        d_set_ph = 1'b1;
                        d_ph     = bdr_pkg::PH_RECV;
                    end else begin
                        d_code   = bdr_pkg::ERR_ERASE;
                        d_set_ph = 1'b1;
                    end
                end
                bdr_pkg::OP_DATA: begin
                    if (r_phase != bdr_pkg::PH_RECV) begin
                        d_code = bdr_pkg::ERR_STATE;
                    end else if (r_bytes_done >= r_image_size) begin
                        d_code = bdr_pkg::ERR_INCOMPLETE;
                    end else if (r_frm.seq >= frames) begin
                        d_code = bdr_pkg::ERR_SEQUENCE;
                    end else if (r_frm.frame_len != 4'(plen) + 4'd1) begin
                        d_code = bdr_pkg::ERR_LENGTH;
                    end else if (dup) begin
                        // repeated frame: resend the map only on the block's last frame
                        if (is_last_frame) begin
                            d_kind = bdr_pkg::KIND_MAP;
                            d_code = bdr_pkg::ERR_LENGTH;
                            d_map  = r_seen;
                        end else begin
                            d_act = bdr_pkg::ACT_NONE;
                        end
                    end else begin
                        d_act = bdr_pkg::ACT_WRITE;
                    end
                end
                bdr_pkg::OP_END: begin
                    if (r_phase != bdr_pkg::PH_RECV) begin
                        d_code = bdr_pkg::ERR_STATE;
                    end else if (r_frm.frame_len != 4'd5) begin
                        d_code = bdr_pkg::ERR_LENGTH;
                    end else if (r_frm.seq != 6'd0) begin
                        d_code = bdr_pkg::ERR_SEQUENCE;
                    end else if (r_bytes_done != r_image_size || r_seen != '0) begin
                        d_code = bdr_pkg::ERR_INCOMPLETE;
                    end else if ((r_crc ^ bdr_pkg::CRC_INIT) != word) begin
                        d_code   = bdr_pkg::ERR_CRC;
                        d_set_ph = 1'b1;
                    end else if (!vec_ok) begin
                        d_code   = bdr_pkg::ERR_IMAGE;
                        d_set_ph = 1'b1;
                    end else if (r_frm.flash_ok) begin
                        d_kind   = bdr_pkg::KIND_ACK;
                        d_code   = bdr_pkg::ERR_LENGTH;
                        d_set_ph = 1'b1;
                        d_ph     = bdr_pkg::PH_VERIFIED;
                    end else begin
                        d_code   = bdr_pkg::ERR_WRITE;
                        d_set_ph = 1'b1;
                    end
                end
                default: begin
                    if (r_frm.frame_len != 4'd1) begin
                        d_code = bdr_pkg::ERR_LENGTH;
                    end else if (r_frm.seq != 6'd0) begin
                        d_code = bdr_pkg::ERR_SEQUENCE;
                    end else if (r_phase != bdr_pkg::PH_VERIFIED) begin
                        d_code = bdr_pkg::ERR_STATE;
                    end else if (vec_ok) begin
                        d_kind = bdr_pkg::KIND_ACK;
                        d_code = bdr_pkg::ERR_LENGTH;
                    end else begin
                        d_code   = bdr_pkg::ERR_IMAGE;
                        d_set_ph = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_status.act      = d_act;
    assign o_status.complete = ((seen_new & target) == target);

    assign wr_pos    = off + BW'(i_cmd.wr_idx);
    assign wr_ok     = i_cmd.wr_en && (i_cmd.wr_idx < plen)
                    && (wr_pos < BW'(bdr_pkg::BLOCK_BYTES));
    assign rd_b      = r_rd_vb ? r_rd_byte : 8'hFF;
    assign full_word = {rd_b, r_word};

    // block memory
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_pos[AW-1:0]] <= r_frm.payload[8*i_cmd.wr_idx +: 8];
        end
        if (i_cmd.rd_en) begin
            r_rd_byte <= mem[i_cmd.rd_addr];
            r_rd_vb   <= r_vbit[i_cmd.rd_addr];
            r_rd_addr <= i_cmd.rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frm <= i_frame;
        end
        if (i_cmd.mark) begin
            r_crc_tmp <= r_crc;
        end
        if (r_rd_vld) begin
            // byte 7 of a word goes straight out through full_word
            if (r_rd_addr[2:0] != 3'd7) begin
                r_word[8*r_rd_addr[2:0] +: 8] <= rd_b;
            end
            if ({1'b0, r_rd_addr} < blk) begin
                r_crc_tmp <= bdr_pkg::crc_byte(r_crc_tmp, rd_b);
            end
            if (r_rd_addr == AW'(7)) begin
                r_vec_tmp <= full_word;
            end
        end
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bdr_pkg::PH_IDLE;
            r_vbit       <= '0;
            r_seen       <= '0;
            r_image_size <= '0;
            r_bytes_done <= '0;
            r_crc        <= bdr_pkg::CRC_INIT;
            r_vec        <= '0;
            r_rd_vld     <= 1'b0;
            r_valid      <= 1'b0;
            r_res        <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_valid  <= 1'b0;
            r_res    <= '0;
            if (wr_ok) begin
                r_vbit[wr_pos[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.exec && d_act == bdr_pkg::ACT_REPLY) begin
                r_valid          <= 1'b1;
                r_res.kind       <= d_kind;
                r_res.err_code   <= d_code;
                r_res.frame_map  <= d_map;
                r_res.last       <= 1'b1;
                if (d_set_ph) begin
                    r_phase <= d_ph;
                end
                if (d_init) begin
                    r_vbit       <= '0;
                    r_seen       <= '0;
                    r_bytes_done <= '0;
                    r_crc        <= bdr_pkg::CRC_INIT;
                    r_vec        <= '0;
                    r_image_size <= word[SW-1:0];
                end
            end
            if (i_cmd.mark) begin
                r_seen <= seen_new;
                if (!o_status.complete && is_last_frame) begin
                    r_valid         <= 1'b1;
                    r_res.kind      <= bdr_pkg::KIND_MAP;
                    r_res.frame_map <= seen_new;
                    r_res.last      <= 1'b1;
                end
            end
            if (r_rd_vld && r_rd_addr[2:0] == 3'd7) begin
                r_valid            <= 1'b1;
                r_res.kind         <= bdr_pkg::KIND_WORD;
                r_res.write_offset <= 20'(r_bytes_done + SW'({r_rd_addr[AW-1:3], 3'b000}));
                r_res.write_data   <= full_word;
            end
            if (i_cmd.finish) begin
                r_valid    <= 1'b1;
                r_res.last <= 1'b1;
                if (r_frm.flash_ok) begin
                    r_res.kind <= bdr_pkg::KIND_ACK;
                    if (r_bytes_done == '0) begin
                        r_vec <= r_vec_tmp;
                    end
                    r_crc        <= r_crc_tmp;
                    r_bytes_done <= r_bytes_done + SW'(blk);
                    r_vbit       <= '0;
                    r_seen       <= '0;
                end else begin
                    r_res.kind     <= bdr_pkg::KIND_ERR;
                    r_res.err_code <= bdr_pkg::ERR_WRITE;
                    r_phase        <= bdr_pkg::PH_FAILED;
                end
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== src/block_download_receiver.sv =====
// Top level of the block download receiver: config registers, controller, datapath.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------
//  frame in  | start, busy              | i_frame  (t_frame)
//  result out| o_valid (one-cycle pulse)| o_result (t_result)
//  config    | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// A frame is taken when start is high and busy is low. Ignored frames and plain
// replies hold busy through the decode state only; a new data frame passes decode,
// seven byte-write slots of the single-port block memory and the bitmap update. The
// frame that completes a block then reads the 256-byte store one byte per cycle,
// feeding the 32 write words and the CRC, then drains and commits the block.
// Each result is formed straight into the output register that drives o_result.
// Reset (synchronous, active low) clears control state and the per-byte valid
// bits at once, so the block store reads as all 0xFF with no clearing pass.
// Results cannot be held off; the receiver must take every pulse.
module block_download_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bdr_pkg::t_frame                    i_frame,
    output logic                               o_valid,
    output bdr_pkg::t_result                   o_result,
    input  logic                               i_cfg_we,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    bdr_pkg::t_cfg    r_cfg;
    bdr_pkg::t_cmd    cmd;
    bdr_pkg::t_status status;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_image_bytes <= 21'd57344;
            r_cfg.ram_low         <= 32'h20000000;
            r_cfg.ram_high        <= 32'h20005000;
            r_cfg.image_base      <= 32'h08000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdr_pkg::REG_MAX_IMAGE:  r_cfg.max_image_bytes <= i_cfg_data[20:0];
                bdr_pkg::REG_RAM_LOW:    r_cfg.ram_low         <= i_cfg_data;
                bdr_pkg::REG_RAM_HIGH:   r_cfg.ram_high        <= i_cfg_data;
                bdr_pkg::REG_IMAGE_BASE: r_cfg.image_base      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bdr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bdr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_frame  (i_frame),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // every result is formed while a transaction is in progress
    a_result_in_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result outside a transaction");

    // write words never close a transaction
    a_word_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind == bdr_pkg::KIND_WORD) |-> !o_result.last)
        else $error("write word marked last");

    // error code is zero unless the result is an error
    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind != bdr_pkg::KIND_ERR) |-> (o_result.err_code == 4'd0))
        else $error("error code on a non-error result");

    // a last result never appears while the block is being read out
    a_last_before_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !(cmd.rd_en))
        else $error("last result during block readout");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the block download receiver: directed, register, download and random frame tests
`timescale 1ns / 100ps

module tb;
    import bdr_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the signals that connect to the receiver
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_frame      i_frame;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    block_download_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_frame    (i_frame),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted receiver state, kept in step with every accepted frame
    // ------------------------------------------------------------------
    logic [20:0] cfg_max_image;
    logic [31:0] cfg_ram_low;
    logic [31:0] cfg_ram_high;
    logic [31:0] cfg_image_base;

    logic [1:0]  dl_phase;
    logic [7:0]  blk_bytes [BLOCK_BYTES];
    logic [36:0] got_frames;
    logic [20:0] img_size;
    logic [20:0] img_done;
    logic [31:0] img_crc;
    logic [63:0] img_vectors;

    // results still owed by the receiver, oldest first
    t_result     pending_results[$];

    int          mismatches;
    int          idle_pct;      // sender idle chance, percent
    int          n_sent;        // frames accepted so far

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    task automatic clear_block_model();
        for (int i = 0; i < BLOCK_BYTES; i++) blk_bytes[i] = 8'hFF;
        got_frames = '0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [3:0] code,
                               input logic [36:0] fmap, input logic [19:0] off,
                               input logic [63:0] data, input logic lst);
        t_result r;
        r.kind = kind;
        r.err_code = code;
        r.frame_map = fmap;
        r.write_offset = off;
        r.write_data = data;
        r.last = lst;
        pending_results.push_back(r);
    endtask

    task automatic push_reply(input logic [1:0] kind, input logic [3:0] code);
        push_result(kind, code, '0, '0, '0, 1'b1);
    endtask

    // stack pointer in RAM window and word aligned, thumb reset vector in image
    function automatic bit vectors_valid();
        logic [31:0] sp;
        logic [31:0] rv;
        logic [32:0] ra;
        logic [32:0] lim;
        sp  = img_vectors[31:0];
        rv  = img_vectors[63:32];
        ra  = {1'b0, rv & 32'hFFFF_FFFE};
        lim = {1'b0, cfg_image_base} + {12'd0, cfg_max_image};
        return !(sp < cfg_ram_low || sp > cfg_ram_high || sp[1:0] != 2'b00 ||
                 !rv[0] || ra < {1'b0, cfg_image_base} || ra >= lim);
    endfunction

    // reflected CRC-32 over the first n bytes of the block
    task automatic fold_block_crc(input int n);
        logic [31:0] c;
        c = img_crc;
        for (int i = 0; i < n && i < BLOCK_BYTES; i++) begin
            c ^= {24'd0, blk_bytes[i]};
            for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        img_crc = c;
    endtask

    task automatic predict_data(input t_frame f);
        int          remain;
        int          blk;
        int          nfr;
        int          off;
        int          plen;
        logic [36:0] target;
        logic [63:0] d;
        if (dl_phase != PH_RECV) begin
            push_reply(KIND_ERR, ERR_STATE);
            return;
        end
        if (img_done >= img_size) begin
            push_reply(KIND_ERR, ERR_INCOMPLETE);
            return;
        end
        remain = img_size - img_done;
        blk = remain > BLOCK_BYTES ? BLOCK_BYTES : remain;
        nfr = (blk + FRAME_BYTES - 1) / FRAME_BYTES;
        if (f.seq >= nfr) begin
            push_reply(KIND_ERR, ERR_SEQUENCE);
            return;
        end
        off = f.seq * FRAME_BYTES;
        plen = (blk - off) > FRAME_BYTES ? FRAME_BYTES : blk - off;
        if (f.frame_len != plen + 1) begin
            push_reply(KIND_ERR, ERR_LENGTH);
            return;
        end
        if (got_frames[f.seq]) begin
            // repeat of the block's last frame re-sends the NACK map
            if (f.seq == nfr - 1) push_result(KIND_MAP, '0, got_frames, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < plen; i++) blk_bytes[off + i] = f.payload[8*i +: 8];
        got_frames[f.seq] = 1'b1;
        target = (37'd1 << nfr) - 37'd1;
        if ((got_frames & target) == target) begin
            for (int w = 0; w < BLOCK_BYTES / 8; w++) begin
                for (int b = 0; b < 8; b++) d[8*b +: 8] = blk_bytes[w*8 + b];
                push_result(KIND_WORD, '0, '0, 20'(img_done + 21'(w * 8)), d, 1'b0);
            end
            if (f.flash_ok) begin
                if (img_done == 0)
                    for (int b = 0; b < 8; b++) img_vectors[8*b +: 8] = blk_bytes[b];
                fold_block_crc(blk);
                img_done += 21'(blk);
                clear_block_model();
                push_reply(KIND_ACK, '0);
            end else begin
                dl_phase = PH_FAILED;
                push_reply(KIND_ERR, ERR_WRITE);
            end
            return;
        end
        if (f.seq == nfr - 1) push_result(KIND_MAP, '0, got_frames, '0, '0, 1'b1);
    endtask

    task automatic predict_frame(input t_frame f);
        logic [31:0] word;
        word = f.payload[31:0];
        if (f.frame_id != BOOT_FRAME_ID || f.frame_len == 0) return;
        case (f.opcode)
            OP_START: begin
                if (f.frame_len != 5) push_reply(KIND_ERR, ERR_LENGTH);
                else if (f.seq != 0) push_reply(KIND_ERR, ERR_SEQUENCE);
                else if (word == 0 || word > {11'd0, cfg_max_image})
                    push_reply(KIND_ERR, ERR_SIZE);
                else if (f.flash_ok) begin
                    clear_block_model();
                    img_done = '0;
                    img_crc = 32'hFFFF_FFFF;
                    img_vectors = '0;
                    img_size = word[20:0];
                    dl_phase = PH_RECV;
                    push_reply(KIND_ACK, '0);
                end else begin
                    dl_phase = PH_FAILED;
                    push_reply(KIND_ERR, ERR_ERASE);
                end
            end
            OP_DATA: predict_data(f);
            OP_END: begin
                if (dl_phase != PH_RECV) push_reply(KIND_ERR, ERR_STATE);
                else if (f.frame_len != 5) push_reply(KIND_ERR, ERR_LENGTH);
                else if (f.seq != 0) push_reply(KIND_ERR, ERR_SEQUENCE);
                else if (img_done != img_size || got_frames != 0)
                    push_reply(KIND_ERR, ERR_INCOMPLETE);
                else if (~img_crc != word) begin
                    dl_phase = PH_FAILED;
                    push_reply(KIND_ERR, ERR_CRC);
                end else if (!vectors_valid()) begin
                    dl_phase = PH_FAILED;
                    push_reply(KIND_ERR, ERR_IMAGE);
                end else if (f.flash_ok) begin
                    dl_phase = PH_VERIFIED;
                    push_reply(KIND_ACK, '0);
                end else begin
                    dl_phase = PH_FAILED;
                    push_reply(KIND_ERR, ERR_WRITE);
                end
            end
            default: begin // OP_JUMP; flash outcome does not matter
                if (f.frame_len != 1) push_reply(KIND_ERR, ERR_LENGTH);
                else if (f.seq != 0) push_reply(KIND_ERR, ERR_SEQUENCE);
                else if (dl_phase != PH_VERIFIED) push_reply(KIND_ERR, ERR_STATE);
                else if (vectors_valid()) push_reply(KIND_ACK, '0);
                else begin
                    dl_phase = PH_FAILED;
                    push_reply(KIND_ERR, ERR_IMAGE);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe is compared against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h at %0t", o_result, $realtime);
            end else begin
                t_result e;
                e = pending_results.pop_front();
                if (o_result.kind !== e.kind || o_result.err_code !== e.err_code ||
                    o_result.frame_map !== e.frame_map ||
                    o_result.write_offset !== e.write_offset ||
                    o_result.write_data !== e.write_data || o_result.last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result mismatch at %0t kind %0d/%0d code %0d/%0d ",
                                  "map %h/%h off %h/%h data %h/%h last %0d/%0d"},
                                 $realtime, e.kind, o_result.kind, e.err_code,
                                 o_result.err_code, e.frame_map, o_result.frame_map,
                                 e.write_offset, o_result.write_offset, e.write_data,
                                 o_result.write_data, e.last, o_result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Transaction drivers
    // ------------------------------------------------------------------
    // one frame: optional random idle, hold start until accepted; the leading
    // edge costs nothing since busy is high for the cycle after an accept
    task automatic send_frame(input t_frame f);
        @(posedge i_clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge i_clk);
        start   <= 1'b1;
        i_frame <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_frame(f);
        n_sent++;
        start <= 1'b0;
    endtask

    // drain: wait for all owed results, then cover frames still in flight
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MAX_IMAGE:  cfg_max_image  = val[20:0];
            REG_RAM_LOW:    cfg_ram_low    = val;
            REG_RAM_HIGH:   cfg_ram_high   = val;
            REG_IMAGE_BASE: cfg_image_base = val;
            default: ;
        endcase
    endtask

    function automatic t_frame mk(input logic [1:0] op, input logic [5:0] sq,
                                  input logic [3:0] len, input logic [55:0] pl,
                                  input logic ok);
        t_frame f;
        f.frame_id = BOOT_FRAME_ID;
        f.opcode = op;
        f.seq = sq;
        f.frame_len = len;
        f.payload = pl;
        f.flash_ok = ok;
        return f;
    endfunction

    function automatic logic [55:0] rand_payload();
        return 56'({$urandom(), $urandom()});
    endfunction

    // full download of an image of given size; frames of each block shuffled,
    // some repeated; with good_vec, vectors placed so the image usually passes
    task automatic download_image(input int size, input bit good_vec, input bit fail_ok);
        int        blk;
        int        nfr;
        int        order[$];
        t_frame    f;
        logic [55:0] pl;
        send_frame(mk(OP_START, 0, 5, 56'(size), 1'b1));
        while (img_done < img_size && dl_phase == PH_RECV) begin
            blk = (img_size - img_done) > BLOCK_BYTES ? BLOCK_BYTES : img_size - img_done;
            nfr = (blk + FRAME_BYTES - 1) / FRAME_BYTES;
            order.delete();
            for (int i = 0; i < nfr; i++) order.push_back(i);
            order.shuffle();
            // sometimes send the last frame early to provoke a NACK
            if ($urandom_range(3) == 0) order.push_front(nfr - 1);
            if ($urandom_range(3) == 0) order.push_back(order[0]);
            foreach (order[i]) begin
                pl = rand_payload();
                // bytes 0..3 stack pointer, bytes 4..6 low reset vector bytes
                if (good_vec && img_done == 0 && order[i] == 0)
                    pl = {24'h000101 | 24'($urandom_range(255) << 8),
                          24'h200010 | 24'($urandom_range(3) << 4), 8'h00};
                if (good_vec && img_done == 0 && order[i] == 1) pl[7:0] = 8'h08;
                f = mk(OP_DATA, 6'(order[i]),
                       4'((blk - order[i]*7) > 7 ? 8 : blk - order[i]*7 + 1),
                       pl, fail_ok ? ($urandom_range(19) != 0) : 1'b1);
                send_frame(f);
            end
        end
        send_frame(mk(OP_END, 0, 5, 56'(~img_crc), ($urandom_range(9) != 0)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_registers();
        write_reg(REG_MAX_IMAGE, 32'd1);
        send_frame(mk(OP_START, 0, 5, 56'd2, 1'b1));      // over size
        send_frame(mk(OP_START, 0, 5, 56'd1, 1'b1));      // smallest image
        send_frame(mk(OP_DATA, 0, 2, 56'hA5, 1'b1));
        send_frame(mk(OP_DATA, 0, 2, 56'hA5, 1'b1));      // data after all bytes
        send_frame(mk(OP_END, 0, 5, 56'd0, 1'b1));        // crc error
        wait_drained();
        write_reg(REG_MAX_IMAGE, 32'h0010_0000);
        write_reg(REG_RAM_LOW, 32'h0);
        write_reg(REG_RAM_HIGH, 32'hFFFF_FFFF);
        write_reg(REG_IMAGE_BASE, 32'hFFFF_FF00);
        write_reg(3'd7, 32'h1234_5678);                   // unknown index
        send_frame(mk(OP_START, 0, 5, 56'h0010_0000, 1'b1));
        send_frame(mk(OP_START, 0, 5, 56'h0010_0001, 1'b1));
        wait_drained();
    endtask

    task automatic test_directed();
        t_frame f;
        f = mk(OP_START, 0, 5, 56'd20, 1'b1);
        f.frame_id = 11'h7FF;
        send_frame(f);                                    // other identifier
        send_frame(mk(OP_START, 0, 0, 56'd20, 1'b1));     // zero length
        send_frame(mk(OP_DATA, 0, 8, '1, 1'b1));          // idle: state error
        send_frame(mk(OP_END, 0, 5, '0, 1'b1));
        send_frame(mk(OP_JUMP, 0, 1, '0, 1'b1));
        send_frame(mk(OP_JUMP, 0, 2, '0, 1'b1));
        send_frame(mk(OP_JUMP, 63, 1, '0, 1'b0));
        send_frame(mk(OP_START, 0, 4, 56'd20, 1'b1));
        send_frame(mk(OP_START, 63, 5, 56'd20, 1'b1));
        send_frame(mk(OP_START, 0, 5, 56'd0, 1'b1));
        send_frame(mk(OP_START, 0, 5, 56'd20, 1'b0));     // erase fails
        send_frame(mk(OP_START, 0, 5, 56'd20, 1'b1));
        send_frame(mk(OP_DATA, 3, 7, '0, 1'b1));          // sequence out of range
        send_frame(mk(OP_DATA, 0, 7, '0, 1'b1));          // wrong length
        send_frame(mk(OP_DATA, 2, 7, '1, 1'b1));          // last frame first: NACK
        send_frame(mk(OP_DATA, 2, 7, '1, 1'b1));          // repeat: NACK again
        send_frame(mk(OP_DATA, 0, 8, 56'hFF_FFFF_FFFF_FFFF, 1'b1));
        send_frame(mk(OP_DATA, 0, 8, '0, 1'b1));          // repeat, dropped
        send_frame(mk(OP_END, 0, 5, '0, 1'b1));           // incomplete
        send_frame(mk(OP_DATA, 1, 8, '0, 1'b0));          // block write fails
        send_frame(mk(OP_END, 0, 5, '0, 1'b1));
        wait_drained();
    endtask

    task automatic test_downloads();
        write_reg(REG_MAX_IMAGE, 32'd57344);
        write_reg(REG_RAM_LOW, 32'h2000_0000);
        write_reg(REG_RAM_HIGH, 32'h2000_5000);
        write_reg(REG_IMAGE_BASE, 32'h0800_0000);
        download_image(256, 1'b1, 1'b0);
        send_frame(mk(OP_JUMP, 0, 1, '0, 1'($urandom_range(1))));
        download_image(300, 1'b1, 1'b0);
        send_frame(mk(OP_JUMP, 0, 1, '0, 1'b1));
        // pause until everything owed has arrived, then move the window
        wait_drained();
        write_reg(REG_RAM_HIGH, 32'h2000_0000);           // jump now fails the vectors
        send_frame(mk(OP_JUMP, 0, 1, '0, 1'b1));
        wait_drained();
        write_reg(REG_RAM_HIGH, 32'h2000_5000);
    endtask

    task automatic test_random();
        t_frame f;
        while (n_sent < 250) begin
            idle_pct = (n_sent >= 150 && n_sent < 190) ? 0 : 7;   // stretch with no idling
            case ($urandom_range(9))
                0, 1, 2: begin
                    download_image($urandom_range(1, 40), $urandom_range(3) != 0, 1'b1);
                end
                3: begin
                    download_image($urandom_range(250, 520), 1'b1, 1'b1);
                end
                4: begin
                    send_frame(mk(OP_JUMP, 0, 1, '0, 1'($urandom_range(1))));
                end
                default: begin
                    f = t_frame'(80'({$urandom(), $urandom(), $urandom()}));
                    if ($urandom_range(3) != 0) f.frame_id = BOOT_FRAME_ID;
                    if ($urandom_range(1)) f.frame_len = 4'($urandom_range(8));
                    if ($urandom_range(1)) f.seq = 6'($urandom_range(6));
                    if (f.opcode == OP_START && $urandom_range(1))
                        f.payload[31:0] = $urandom_range(1, 60);
                    send_frame(f);
                end
            endcase
        end
        idle_pct = 7;
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_frame    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches = 0;
        n_sent     = 0;
        idle_pct   = 7;
        cfg_max_image  = 21'd57344;
        cfg_ram_low    = 32'h2000_0000;
        cfg_ram_high   = 32'h2000_5000;
        cfg_image_base = 32'h0800_0000;
        dl_phase    = PH_IDLE;
        clear_block_model();
        img_size    = '0;
        img_done    = '0;
        img_crc     = 32'hFFFF_FFFF;
        img_vectors = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_registers();
        test_downloads();
        test_random();
        wait_drained();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("block_download_receiver verification clean");
        else
            $display("block_download_receiver verification failed");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #20ms;
        $display("block_download_receiver verification failed");
        $finish;
    end

endmodule
